FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the ray grid generator RTL.
// Checks are compiled in only when synthesis is not defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CRG_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("check failed");
`define CRG_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("check failed");
`else
`define CRG_ASSERT(lbl, clk, rstn, prop)
`define CRG_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: rtl/crg_pkg.sv
// ----------------------------------------------------------------------------
// crg_pkg
// Shared widths, register indexes, word types and helpers for the
// camera ray grid generator.
// ----------------------------------------------------------------------------
`default_nettype none
package crg_pkg;
    localparam int PIX_BITS    = 12;
    localparam int DIR_W       = 24;
    localparam int COMP_W      = 20;
    localparam int DIM_W       = 16;
    localparam int SPS_W       = 4;
    localparam int CFG_W       = 60;
    localparam int REG_IDX_W   = 3;
    localparam int SIDX_W      = 6;
    localparam int DEF_MAX_SPS = 8;
    localparam int NUM_W       = 18;
    localparam int P1_W        = COMP_W + DIM_W + 1;
    localparam int PROD_W      = 53;
    localparam int DIV_W       = 52;
    localparam int DEN_W       = 20;
    localparam int ACC_W       = 55;

    localparam logic [REG_IDX_W-1:0] REG_CAM_POS = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FORWARD = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RIGHT   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_UP      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_VIEWPT  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SPS     = 3'd6;

    typedef struct packed {
        logic [PIX_BITS-1:0] pixel_col;
        logic [PIX_BITS-1:0] pixel_row;
    } crg_in_t;

    typedef struct packed {
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
        logic [SIDX_W-1:0]       sample_index;
        logic                    last_sample;
    } crg_out_t;

    // divider handshake from the sequencer
    typedef struct packed {
        logic                start;
        logic [DIV_W-1:0]    num;
        logic [DEN_W-1:0]    den;
    } crg_div_req_t;

    function automatic logic signed [COMP_W-1:0] comp20(
        input logic [CFG_W-1:0] packed_v,
        input logic [1:0]       k
    );
        logic signed [COMP_W-1:0] r;
        case (k)
            2'd0:    r = packed_v[COMP_W-1:0];
            2'd1:    r = packed_v[2*COMP_W-1:COMP_W];
            default: r = packed_v[3*COMP_W-1:2*COMP_W];
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

FILE: rtl/crg_div.sv
// ----------------------------------------------------------------------------
// crg_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module crg_div
    import crg_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire crg_div_req_t     req,
    output logic                  done,
    output logic [DIV_W-1:0]      quo
);
    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] q_reg, q_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic             qbit;

    always_comb
    begin
        trial     = {rem_reg, q_reg[DIV_W-1]};
        qbit      = (trial >= {1'b0, den_reg});
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next = '0;
            q_next   = req.num;
            cnt_next = CNT_W'(DIV_W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            // shift in next dividend bit, subtract when it fits
            rem_next = qbit ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            q_next   = {q_reg[DIV_W-2:0], qbit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if (req.start)
        begin
            den_reg <= req.den;
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;
endmodule
`default_nettype wire

FILE: rtl/camera_ray_grid_generator_core.sv
// ----------------------------------------------------------------------------
// camera_ray_grid_generator_core
// Pinhole primary ray generator with an L x L supersampling grid per pixel.
// ----------------------------------------------------------------------------
// Each sample takes six terms (right and up for x, y, z), each a multiply,
// a second multiply and a pass of the shared divider.
// busy rises at the accepting edge and drops in the cycle that shows the last ray.
// Rays appear on result for one cycle under strobe; the receiver cannot stall.
// Reset clears the sequencer and all configuration registers (L resets to 1).
`default_nettype none
`include "assert_macros.svh"
module camera_ray_grid_generator_core
    import crg_pkg::*;
#(
    parameter int MAX_SAMPLES_PER_SIDE = DEF_MAX_SPS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire crg_in_t              item,
    output logic                      strobe,
    output crg_out_t                  result,
    input  wire logic                 wr_en,
    input  wire logic [REG_IDX_W-1:0] wr_index,
    input  wire logic [CFG_W-1:0]     wr_data
);
    localparam int RC_W = (MAX_SAMPLES_PER_SIDE > 1) ? $clog2(MAX_SAMPLES_PER_SIDE) : 1;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_MUL2 = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(8388607);
    localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(8388608);

    // configuration words; the eye point cancels out of every direction
    logic [CFG_W-1:0]      fwd_reg, right_reg, up_reg;
    logic [2*DIM_W-1:0]    vp_reg;
    logic [2*PIX_BITS-1:0] img_reg;
    logic [SPS_W-1:0]      sps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg   <= '0;
            right_reg <= '0;
            up_reg    <= '0;
            vp_reg    <= '0;
            img_reg   <= '0;
            sps_reg   <= SPS_W'(1);
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_CAM_POS: ; // held by software only
                REG_FORWARD: fwd_reg   <= wr_data;
                REG_RIGHT:   right_reg <= wr_data;
                REG_UP:      up_reg    <= wr_data;
                REG_VIEWPT:  vp_reg    <= wr_data[2*DIM_W-1:0];
                REG_IMAGE:   img_reg   <= wr_data[2*PIX_BITS-1:0];
                REG_SPS:     sps_reg   <= wr_data[SPS_W-1:0];
                default: ;   // drop writes to unknown indexes
            endcase
        end
    end

    // per-pixel setup, evaluated at the accepting edge
    logic [PIX_BITS-1:0]      nx_eff, ny_eff;
    logic [SPS_W-1:0]         l_eff;
    logic [PIX_BITS+SPS_W-1:0] lnx, lny;
    logic signed [NUM_W-1:0]  basex_calc, basey_calc;

    always_comb
    begin
        nx_eff = (img_reg[PIX_BITS-1:0] == '0) ? PIX_BITS'(1) : img_reg[PIX_BITS-1:0];
        ny_eff = (img_reg[2*PIX_BITS-1:PIX_BITS] == '0) ? PIX_BITS'(1)
                                                        : img_reg[2*PIX_BITS-1:PIX_BITS];
        if (sps_reg == '0)
            l_eff = SPS_W'(1);
        else if (sps_reg > SPS_W'(MAX_SAMPLES_PER_SIDE))
            l_eff = SPS_W'(MAX_SAMPLES_PER_SIDE);
        else
            l_eff = sps_reg;
        lnx = (PIX_BITS+SPS_W)'(l_eff) * (PIX_BITS+SPS_W)'(nx_eff);
        lny = (PIX_BITS+SPS_W)'(l_eff) * (PIX_BITS+SPS_W)'(ny_eff);
        // numx = 2L*col + 2c + 1 - L*nX, numy = L*nY - 2L*(row+1) + 2r + 1
        basex_calc = NUM_W'({l_eff, 1'b0} * item.pixel_col) + NUM_W'(1) - NUM_W'(lnx);
        basey_calc = NUM_W'(lny) - NUM_W'({l_eff, 1'b0} * (item.pixel_row + 1'b1))
                     + NUM_W'(1);
    end

    logic [2:0]              state_reg, state_next;
    logic [SPS_W-1:0]        l_reg;
    logic [DEN_W-1:0]        denx_reg, deny_reg;
    logic signed [NUM_W-1:0] basex_reg, basey_reg;
    logic [RC_W-1:0]         r_reg, c_reg;
    logic [SIDX_W-1:0]       samp_reg;
    logic [1:0]              k_reg;
    logic                    t_reg;
    logic signed [P1_W-1:0]  p1_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [DIR_W-1:0] dir_reg [3];
    logic                    strobe_reg;
    crg_out_t                res_reg;

    crg_div_req_t            dreq;
    logic                    ddone;
    logic [DIV_W-1:0]        dquo;

    logic signed [COMP_W-1:0] axis_c;
    logic [DIM_W-1:0]         dim_c;
    logic signed [NUM_W-1:0]  num_c;
    logic [DIV_W-1:0]         mag_c;
    logic signed [DIV_W:0]    term_c;
    logic signed [ACC_W-1:0]  sum_c;
    logic signed [DIR_W-1:0]  sat_c;
    logic                     last_c;

    always_comb
    begin
        axis_c = t_reg ? comp20(up_reg, k_reg) : comp20(right_reg, k_reg);
        dim_c  = t_reg ? vp_reg[2*DIM_W-1:DIM_W] : vp_reg[DIM_W-1:0];
        num_c  = t_reg ? basey_reg + NUM_W'({r_reg, 1'b0})
                       : basex_reg + NUM_W'({c_reg, 1'b0});
        dreq.start = (state_reg == S_DIV);
        dreq.den   = t_reg ? deny_reg : denx_reg;
        // magnitude plus half the divisor: round half away from zero
        mag_c  = prod_reg[PROD_W-1] ? DIV_W'(-prod_reg) : DIV_W'(prod_reg);
        mag_c  = mag_c + DIV_W'(dreq.den >> 1);
        dreq.num   = mag_c;
        term_c = prod_reg[PROD_W-1] ? -$signed({1'b0, dquo}) : $signed({1'b0, dquo});
        sum_c  = acc_reg + ACC_W'(term_c);
        if (sum_c > SAT_HI)
            sat_c = DIR_W'(SAT_HI);
        else if (sum_c < SAT_LO)
            sat_c = DIR_W'(SAT_LO);
        else
            sat_c = DIR_W'(sum_c);
        last_c = (r_reg == RC_W'(l_reg - 1'b1)) && (c_reg == RC_W'(l_reg - 1'b1));

        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (start) state_next = S_MUL1;
            S_MUL1: state_next = S_MUL2;
            S_MUL2: state_next = S_DIV;
            S_DIV:  state_next = S_WAIT;
            S_WAIT:
            begin
                if (ddone)
                    state_next = (t_reg && k_reg == 2'd2) ? S_EMIT : S_MUL1;
            end
            S_EMIT: state_next = last_c ? S_IDLE : S_MUL1;
            default: state_next = S_IDLE;
        endcase
    end

    crg_div u_div
    (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (dreq),
        .done (ddone),
        .quo  (dquo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            strobe_reg <= 1'b0;
            r_reg      <= '0;
            c_reg      <= '0;
            samp_reg   <= '0;
            k_reg      <= '0;
            t_reg      <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= (state_reg == S_EMIT);
            if (state_reg == S_IDLE && start)
            begin
                r_reg    <= '0;
                c_reg    <= '0;
                samp_reg <= '0;
                k_reg    <= '0;
                t_reg    <= 1'b0;
            end
            else if (state_reg == S_WAIT && ddone)
            begin
                // advance term, then component
                t_reg <= ~t_reg;
                if (t_reg)
                    k_reg <= (k_reg == 2'd2) ? 2'd0 : k_reg + 1'b1;
            end
            else if (state_reg == S_EMIT)
            begin
                samp_reg <= samp_reg + 1'b1;
                if (c_reg == RC_W'(l_reg - 1'b1))
                begin
                    c_reg <= '0;
                    r_reg <= r_reg + 1'b1;
                end
                else
                begin
                    c_reg <= c_reg + 1'b1;
                end
            end
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            l_reg     <= l_eff;
            denx_reg  <= DEN_W'({lnx, 5'b0});
            deny_reg  <= DEN_W'({lny, 5'b0});
            basex_reg <= basex_calc;
            basey_reg <= basey_calc;
        end
        if (state_reg == S_MUL1)
        begin
            p1_reg <= axis_c * $signed({1'b0, dim_c});
            if (!t_reg)
                acc_reg <= ACC_W'(comp20(fwd_reg, k_reg));
        end
        if (state_reg == S_MUL2)
            prod_reg <= PROD_W'(p1_reg * num_c);
        if (state_reg == S_WAIT && ddone)
        begin
            acc_reg <= sum_c;
            if (t_reg)
                dir_reg[k_reg] <= sat_c;
        end
        if (state_reg == S_EMIT)
        begin
            res_reg.dir_x        <= dir_reg[0];
            res_reg.dir_y        <= dir_reg[1];
            res_reg.dir_z        <= dir_reg[2];
            res_reg.sample_index <= samp_reg;
            res_reg.last_sample  <= last_c;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign result = res_reg;

    `CRG_ASSERT(a_last_frees, clk, rst_n, (strobe && result.last_sample) |-> !busy)
    `CRG_ASSERT(a_mid_busy, clk, rst_n, (strobe && !result.last_sample) |-> busy)
    `CRG_ASSERT(a_start_takes, clk, rst_n, (start && !busy) |=> busy)
    `CRG_ASSERT(a_strobe_gap, clk, rst_n, strobe |=> !strobe)
endmodule
`default_nettype wire

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the camera ray grid generator core. A directed
// table walks the register extremes, saturation and the degenerate grid and
// image sizes. Random phases with fresh register settings follow. Every ray
// word is checked field by field against an in-bench predictor of the pixel
// subgrid directions or, for typed directed rows, against the typed word.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top
    import crg_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 40_000_000;
    localparam int     NUM_REGS    = 7;
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    crg_in_t              item;
    logic                 strobe;
    crg_out_t             result;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] wr_index;
    logic [CFG_W-1:0]     wr_data;

    camera_ray_grid_generator_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item     (item),
        .strobe   (strobe),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // Shadow copy of the register file, updated as each write is issued.
    logic [CFG_W-1:0] shadow_regs [NUM_REGS];
    // Ray words still owed by the block, oldest first.
    crg_out_t         pending_rays [$];
    int               mismatches = 0;
    longint           cycle_count = 0;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Hard stop: a hung handshake must not run forever.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor
    function automatic longint axis_comp(input logic [CFG_W-1:0] v, input int k);
        logic signed [COMP_W-1:0] c;
        c = v[k*COMP_W +: COMP_W];
        return longint'(c);
    endfunction

    // Nearest Q.12 step, ties away from zero; den is always positive.
    function automatic longint round_nearest(input longint num, input longint den);
        if (num >= 0)
            return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    function automatic logic signed [DIR_W-1:0] clip_dir(input longint v);
        if (v > 64'sd8388607)
            v = 64'sd8388607;
        if (v < -64'sd8388608)
            v = -64'sd8388608;
        return v[DIR_W-1:0];
    endfunction

    // Queue every ray of one pixel's subgrid, bottom row first.
    function automatic void predict_pixel_rays(input longint col, input longint row);
        longint   nx, ny, ww, hh, grid, numx, numy, tx, ty;
        longint   d [3];
        crg_out_t ray;
        nx   = longint'(shadow_regs[REG_IMAGE][PIX_BITS-1:0]);
        ny   = longint'(shadow_regs[REG_IMAGE][2*PIX_BITS-1:PIX_BITS]);
        ww   = longint'(shadow_regs[REG_VIEWPT][DIM_W-1:0]);
        hh   = longint'(shadow_regs[REG_VIEWPT][2*DIM_W-1:DIM_W]);
        grid = longint'(shadow_regs[REG_SPS][SPS_W-1:0]);
        if (nx == 0) nx = 1;
        if (ny == 0) ny = 1;
        if (grid == 0) grid = 1;
        if (grid > DEF_MAX_SPS) grid = DEF_MAX_SPS;
        for (longint r = 0; r < grid; r++)
        begin
            numy = grid * ny - 2 * grid * (row + 1) + 2 * r + 1;
            for (longint c = 0; c < grid; c++)
            begin
                numx = 2 * grid * col + 2 * c + 1 - grid * nx;
                for (int k = 0; k < 3; k++)
                begin
                    tx = round_nearest(axis_comp(shadow_regs[REG_RIGHT], k) * ww * numx,
                                       32 * grid * nx);
                    ty = round_nearest(axis_comp(shadow_regs[REG_UP], k) * hh * numy,
                                       32 * grid * ny);
                    d[k] = axis_comp(shadow_regs[REG_FORWARD], k) + tx + ty;
                end
                ray.dir_x        = clip_dir(d[0]);
                ray.dir_y        = clip_dir(d[1]);
                ray.dir_z        = clip_dir(d[2]);
                ray.sample_index = SIDX_W'(r * grid + c);
                ray.last_sample  = (r == grid - 1) && (c == grid - 1);
                pending_rays.push_back(ray);
            end
        end
    endfunction

    // ------------------------------------------------------------------ checker
    // The receiver cannot stall, so every strobe is a ray word taken now.
    always @(posedge clk)
    begin
        crg_out_t want;
        if (rst_n && strobe)
        begin
            if (pending_rays.size() == 0)
            begin
                $error("ray word with nothing expected");
                mismatches++;
            end
            else
            begin
                want = pending_rays.pop_front();
                if (result.dir_x !== want.dir_x)
                begin
                    $error("dir_x exp %0d got %0d", want.dir_x, result.dir_x);
                    mismatches++;
                end
                if (result.dir_y !== want.dir_y)
                begin
                    $error("dir_y exp %0d got %0d", want.dir_y, result.dir_y);
                    mismatches++;
                end
                if (result.dir_z !== want.dir_z)
                begin
                    $error("dir_z exp %0d got %0d", want.dir_z, result.dir_z);
                    mismatches++;
                end
                if (result.sample_index !== want.sample_index)
                begin
                    $error("sample_index exp %0d got %0d", want.sample_index,
                           result.sample_index);
                    mismatches++;
                end
                if (result.last_sample !== want.last_sample)
                begin
                    $error("last_sample exp %0d got %0d", want.last_sample,
                           result.last_sample);
                    mismatches++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- stimulus
    // Mostly back to back, sometimes a short pause, rarely a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Issue one register write at the next edge; end a burst with end_writes.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        if (idx < NUM_REGS)
            shadow_regs[idx] = val;
    endtask

    task automatic end_writes();
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    // Hold start high until the block takes the word; leave start high so a
    // following word with no gap goes straight out.
    task automatic send_pixel(input logic [PIX_BITS-1:0] col, input logic [PIX_BITS-1:0] row);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start          <= 1'b1;
        item.pixel_col <= col;
        item.pixel_row <= row;
        do
            @(posedge clk);
        while (busy);
        predict_pixel_rays(longint'(col), longint'(row));
    endtask

    // Drop start and drain every owed ray before touching the registers.
    task automatic drain();
        @(posedge clk);
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_rays.size() != 0 || busy);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [CFG_W-1:0] rand60();
        return CFG_W'({$urandom, $urandom});
    endfunction

    // Unit-ish vector: three components within about one unit, or one time in four a fully random word.
    function automatic logic [CFG_W-1:0] rand_axis();
        logic [CFG_W-1:0] v;
        if ($urandom_range(0, 3) == 0)
            return rand60();
        for (int k = 0; k < 3; k++)
            v[k*COMP_W +: COMP_W] = COMP_W'($urandom_range(0, 8192) - 4096);
        return v;
    endfunction

    task automatic randomize_regs(input int grid);
        logic [PIX_BITS-1:0] nx, ny;
        int                  roll;
        roll = $urandom_range(0, 9);
        nx   = (roll == 0) ? 12'd0 : (roll == 1) ? 12'hFFF : 12'($urandom_range(1, 64));
        roll = $urandom_range(0, 9);
        ny   = (roll == 0) ? 12'd0 : (roll == 1) ? 12'hFFF : 12'($urandom_range(1, 64));
        write_reg(REG_CAM_POS, rand60());
        write_reg(REG_FORWARD, rand_axis());
        write_reg(REG_RIGHT, rand_axis());
        write_reg(REG_UP, rand_axis());
        write_reg(REG_VIEWPT, CFG_W'($urandom));
        write_reg(REG_IMAGE, CFG_W'({ny, nx}));
        write_reg(REG_SPS, CFG_W'(grid));
        end_writes();
    endtask

    // Directed rows; expectations typed in only for single-ray pixels whose
    // direction can be read off at once.
    typedef struct {
        int ph;
        int col;
        int row;
        bit typed;
        int ex;
        int ey;
        int ez;
    } pixel_row_t;

    localparam int NUM_DIRECTED = 18;
    pixel_row_t directed [NUM_DIRECTED] = '{
        // all registers at reset: every ray is zero
        '{0, 0,    0,    1, 0, 0, 0},
        '{0, 4095, 4095, 1, 0, 0, 0},
        '{0, 4095, 0,    1, 0, 0, 0},
        // forward at the top of its range, no lateral terms
        '{1, 0,    4095, 1, 524287, 524287, 524287},
        '{1, 2048, 2048, 1, 524287, 524287, 524287},
        // forward at the bottom of its range
        '{2, 1,    2,    1, -524288, -524288, -524288},
        // huge right term past the image edge saturates high
        '{3, 4095, 0,    1, 8388607, 8388607, 8388607},
        // and low once right and forward flip sign
        '{4, 4095, 0,    1, -8388608, -8388608, -8388608},
        // zero grid size and zero image size
        '{5, 0,    0,    0, 0, 0, 0},
        '{5, 1,    0,    0, 0, 0, 0},
        '{5, 4095, 4095, 0, 0, 0, 0},
        // oversized grid clamps to the full 8 x 8
        '{6, 3,    2,    0, 0, 0, 0},
        // 2 x 2 grid, inside and far outside the image
        '{7, 0,    0,    0, 0, 0, 0},
        '{7, 7,    5,    0, 0, 0, 0},
        '{7, 4095, 4095, 0, 0, 0, 0},
        '{7, 2730, 1365, 0, 0, 0, 0},
        '{7, 1365, 2730, 0, 0, 0, 0},
        '{7, 8,    6,    0, 0, 0, 0}
    };

    task automatic setup_phase(input int ph);
        case (ph)
            1: write_reg(REG_FORWARD, {3{20'h7FFFF}});
            2:
            begin
                write_reg(REG_CAM_POS, {3{20'h12345}});
                write_reg(REG_FORWARD, {3{20'h80000}});
            end
            3:
            begin
                write_reg(REG_FORWARD, {3{20'h7FFFF}});
                write_reg(REG_RIGHT, {3{20'h7FFFF}});
                write_reg(REG_VIEWPT, 60'hFFFF_FFFF);
                write_reg(REG_IMAGE, {36'd0, 12'd1, 12'd1});
            end
            4:
            begin
                write_reg(REG_FORWARD, {3{20'h80000}});
                write_reg(REG_RIGHT, {3{20'h80000}});
            end
            5:
            begin
                write_reg(REG_FORWARD, {20'd8192, 20'd0, 20'd0});
                write_reg(REG_RIGHT, {20'd0, 20'd0, 20'd4096});
                write_reg(REG_UP, {20'd0, 20'd4096, 20'd0});
                write_reg(REG_VIEWPT, {28'd0, 16'h0180, 16'h0200});
                write_reg(REG_IMAGE, {CFG_W{1'b0}});
                write_reg(REG_SPS, 60'd0);
            end
            6:
            begin
                write_reg(REG_IMAGE, {36'd0, 12'd6, 12'd8});
                write_reg(REG_SPS, 60'd15);
                // Index past the register file: the write must change nothing.
                write_reg(REG_UNUSED, rand60());
            end
            7: write_reg(REG_SPS, 60'd2);
            default: ;
        endcase
        end_writes();
    endtask

    initial
    begin
        int       cur_ph;
        int       grid, items, col, row;
        crg_out_t typed_ray;

        mismatches  = 0;
        cycle_count = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        item        = '0;
        wr_en       = 1'b0;
        wr_index    = '0;
        wr_data     = '0;
        for (int i = 0; i < NUM_REGS; i++)
            shadow_regs[i] = '0;
        shadow_regs[REG_SPS] = 60'd1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cur_ph = 0;
        foreach (directed[n])
        begin
            if (directed[n].ph != cur_ph)
            begin
                drain();
                cur_ph = directed[n].ph;
                setup_phase(cur_ph);
            end
            if (directed[n].typed)
            begin
                // Hold the typed word in place of the predicted one.
                send_pixel(PIX_BITS'(directed[n].col), PIX_BITS'(directed[n].row));
                void'(pending_rays.pop_back());
                typed_ray.dir_x        = DIR_W'(directed[n].ex);
                typed_ray.dir_y        = DIR_W'(directed[n].ey);
                typed_ray.dir_z        = DIR_W'(directed[n].ez);
                typed_ray.sample_index = '0;
                typed_ray.last_sample  = 1'b1;
                pending_rays.push_back(typed_ray);
            end
            else
                send_pixel(PIX_BITS'(directed[n].col), PIX_BITS'(directed[n].row));
        end

        // Random phases: small grids carry the bulk, full grids only a few.
        for (int p = 0; p < 9; p++)
        begin
            drain();
            if (p == 3)
                grid = 8;
            else if (p == 6)
                grid = $urandom_range(9, 15);
            else
                grid = $urandom_range(0, 3);
            items = (grid > 3) ? 4 : 48;
            randomize_regs(grid);
            for (int n = 0; n < items; n++)
            begin
                // Mostly pixels inside the image or just past its far edge, the rest anywhere.
                if ($urandom_range(0, 9) < 8)
                begin
                    col = $urandom_range(0, shadow_regs[REG_IMAGE][PIX_BITS-1:0]);
                    row = $urandom_range(0, shadow_regs[REG_IMAGE][2*PIX_BITS-1:PIX_BITS]);
                end
                else
                begin
                    col = $urandom_range(0, 4095);
                    row = $urandom_range(0, 4095);
                end
                send_pixel(PIX_BITS'(col), PIX_BITS'(row));
            end
        end

        drain();
        repeat (400) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire

FILE: camera_ray_grid_generator_core.f
+incdir+rtl
rtl/crg_pkg.sv
rtl/crg_div.sv
rtl/camera_ray_grid_generator_core.sv
test/tb_top.sv
